### rtl/jss_pkg.sv
package jss_pkg;

   typedef logic [1:0] lit_kind_type;
   typedef logic [2:0] lit_pos_type;
   typedef logic [3:0] record_kind_type;
   typedef logic [1:0] csr_index_type;

   // Literal kinds under speculative match.
   localparam lit_kind_type LIT_NONE  = 2'd0;
   localparam lit_kind_type LIT_TRUE  = 2'd1;
   localparam lit_kind_type LIT_FALSE = 2'd2;
   localparam lit_kind_type LIT_NULL  = 2'd3;

   // Configuration register indexes.
   localparam csr_index_type CSR_QUOTE_INCLUSIVE = 2'd0;
   localparam csr_index_type CSR_EMIT_INDEXES    = 2'd1;
   localparam csr_index_type CSR_EMIT_MASK       = 2'd2;

   // Record kinds on the result channel.
   localparam record_kind_type KIND_MASK    = 4'd0;
   localparam record_kind_type KIND_INDEX   = 4'd1;
   localparam record_kind_type KIND_SUMMARY = 4'd2;
   localparam int NUM_KINDS = 15;

   // Summary counter slots, in output order.
   localparam int S_BYTES  = 0;
   localparam int S_STRLIT = 1;
   localparam int S_STRCHR = 2;
   localparam int S_NUM    = 3;
   localparam int S_TRUE   = 4;
   localparam int S_FALSE  = 5;
   localparam int S_NULL   = 6;
   localparam int S_OBJ    = 7;
   localparam int S_ARR    = 8;
   localparam int S_STRUCT = 9;
   localparam int S_COLON  = 10;
   localparam int S_COMMA  = 11;
   localparam int S_MAXD   = 12;
   localparam int NUM_SUM  = 13;

   // Characters of interest.
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_UP_E   = 8'h45;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;

   // Expected character of a literal at a given position.
   function automatic logic [7:0] lit_char(input lit_kind_type kind, input lit_pos_type pos);
      logic [7:0] ch;
      ch = 8'h00;
      unique case (kind)
         LIT_TRUE: begin
            unique case (pos)
               3'd0: ch = "t";
               3'd1: ch = "r";
               3'd2: ch = "u";
               3'd3: ch = "e";
               default: ch = 8'h00;
            endcase
         end
         LIT_FALSE: begin
            unique case (pos)
               3'd0: ch = "f";
               3'd1: ch = "a";
               3'd2: ch = "l";
               3'd3: ch = "s";
               3'd4: ch = "e";
               default: ch = 8'h00;
            endcase
         end
         LIT_NULL: begin
            unique case (pos)
               3'd0: ch = "n";
               3'd1: ch = "u";
               3'd2: ch = "l";
               3'd3: ch = "l";
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Position of the final character of a literal.
   function automatic lit_pos_type lit_end(input lit_kind_type kind);
      lit_pos_type p;
      unique case (kind)
         LIT_FALSE: p = 3'd4;
         default:   p = 3'd3;
      endcase
      return p;
   endfunction

   function automatic logic is_number_byte(input logic [7:0] c);
      return ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_MINUS) || (c == CH_PLUS) ||
             (c == CH_DOT) || (c == CH_LOW_E) || (c == CH_UP_E);
   endfunction

endpackage

### rtl/jss_req_if.sv
interface jss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/jss_rsp_if.sv
interface jss_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  record_kind;
   logic [31:0] record_value;
   logic        last_of_run;

   modport source (output valid, output record_kind, output record_value,
                   output last_of_run, input ready);
   modport sink   (input valid, input record_kind, input record_value,
                   input last_of_run, output ready);
endinterface

### rtl/json_structural_scanner.sv
// Channel  | Direction | Beat contents
// ---------+-----------+-------------------------------------------------
// req_bus  | in        | data_byte, last_byte
// rsp_bus  | out       | record_kind, record_value, last_of_run
// csr_*    | in        | write enable, register index, one data bit
//
// A document byte is fully processed in the cycle it is accepted; its results
// are staged in a pending record set that drains one beat per cycle while the
// result channel is ready. A byte causing at most one record sustains one byte
// per cycle on the same condition. A byte causing more records (up to 15 on
// the last byte) holds the input until its final record leaves. Reset is
// synchronous and active high. While any record is pending, a stalled result
// channel stalls the input.
module json_structural_scanner #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   jss_req_if.sink                req_bus,
   jss_rsp_if.source              rsp_bus,
   input  logic                   csr_we,
   input  jss_pkg::csr_index_type csr_index,
   input  logic                   csr_wdata
);
   import jss_pkg::*;

   // Comparison width that covers both the 32-bit depth and the counters.
   localparam int CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
   localparam logic [CMP_W-1:0] CNT_MAX_EXT = CMP_W'({COUNT_WIDTH{1'b1}});
   localparam logic [CMP_W-1:0] POS_MAX_EXT = CMP_W'(32'hFFFF_FFFF);

   // Configuration registers.
   logic quote_incl_ff, emit_idx_ff, emit_mask_ff;

   // Document state.
   logic             str_open_ff, str_open_in;
   logic             odd_esc_ff, odd_esc_in;
   logic             prev_mask_ff, prev_mask_in;
   logic             num_open_ff, num_open_in;
   lit_kind_type     lit_kind_ff, lit_kind_in;
   lit_pos_type      lit_pos_ff, lit_pos_in;
   logic [31:0]      byte_pos_ff, byte_pos_in;
   logic [31:0]      depth_ff, depth_in;
   logic [COUNT_WIDTH-1:0] cnt_ff [NUM_SUM];
   logic [COUNT_WIDTH-1:0] cnt_in [NUM_SUM];
   logic [COUNT_WIDTH-1:0] cnt_next [NUM_SUM];
   logic [COUNT_WIDTH-1:0] qdelim_ff, qdelim_in, qdelim_next;

   // Pending result records: one bit per record kind still to be sent.
   logic [NUM_KINDS-1:0] pend_ff, pend_in, pend_new;
   logic                 mask_rec_ff, mask_rec_in;
   logic [31:0]          idx_rec_ff, idx_rec_in;
   logic [31:0]          snap_ff [NUM_SUM];
   logic [31:0]          snap_in [NUM_SUM];

   // Per-byte decode.
   logic [7:0]           c;
   logic                 m;
   logic                 fresh;
   logic                 structural;
   logic [NUM_SUM-1:0]   inc;
   logic                 qdelim_inc;
   logic                 opener;
   logic [31:0]          depth_up;
   logic [COUNT_WIDTH-1:0] maxd_next;

   logic accept, drain;
   record_kind_type      sel_kind;
   logic [NUM_KINDS-1:0] sel_onehot;
   logic                 final_beat;

   assign accept = req_bus.valid & req_bus.ready;
   assign drain  = rsp_bus.valid & rsp_bus.ready;

   // Mask derivation and classification of the byte under acceptance.
   always_comb begin
      c            = req_bus.data_byte;
      str_open_in  = str_open_ff;
      odd_esc_in   = odd_esc_ff;
      num_open_in  = num_open_ff;
      lit_kind_in  = lit_kind_ff;
      lit_pos_in   = lit_pos_ff;
      depth_in     = depth_ff;
      inc          = '0;
      qdelim_inc   = 1'b0;
      structural   = 1'b0;
      opener       = 1'b0;
      fresh        = 1'b1;
      depth_up     = (depth_ff == 32'hFFFF_FFFF) ? depth_ff : depth_ff + 32'd1;

      // A backslash flips the escape parity; an unescaped quote toggles the
      // string state. Quotes are masked only in the quote-inclusive mode,
      // or when escaped inside a string.
      if (c == CH_BSLASH) begin
         m          = str_open_ff;
         odd_esc_in = ~odd_esc_ff;
      end else if (c == CH_QUOTE) begin
         odd_esc_in = 1'b0;
         m          = quote_incl_ff | (odd_esc_ff & str_open_ff);
         if (!odd_esc_ff) begin
            str_open_in = ~str_open_ff;
         end
      end else begin
         odd_esc_in = 1'b0;
         m          = str_open_ff;
      end

      inc[S_BYTES] = 1'b1;

      // Speculative literal match. A mismatching byte falls through and is
      // classified as if no literal were open.
      if (lit_kind_ff != LIT_NONE) begin
         lit_kind_in = LIT_NONE;
         lit_pos_in  = '0;
         if (!m && (c == lit_char(lit_kind_ff, lit_pos_ff))) begin
            fresh = 1'b0;
            if (lit_pos_ff == lit_end(lit_kind_ff)) begin
               unique case (lit_kind_ff)
                  LIT_TRUE:  inc[S_TRUE]  = 1'b1;
                  LIT_FALSE: inc[S_FALSE] = 1'b1;
                  default:   inc[S_NULL]  = 1'b1;
               endcase
            end else begin
               lit_kind_in = lit_kind_ff;
               lit_pos_in  = lit_pos_ff + 3'd1;
            end
         end
      end

      // An open number swallows further unmasked number bytes.
      if (fresh && num_open_ff) begin
         if (!m && is_number_byte(c)) begin
            fresh = 1'b0;
         end else begin
            num_open_in = 1'b0;
         end
      end

      if (fresh) begin
         if (m) begin
            if (c == CH_QUOTE) begin
               inc[S_STRLIT] = ~prev_mask_ff;
            end else begin
               inc[S_STRCHR] = 1'b1;
            end
         end else begin
            priority case (c)
               CH_QUOTE: qdelim_inc = 1'b1;
               CH_SPACE, CH_LF, CH_CR, CH_TAB: ;
               CH_LBRACE, CH_LBRACK: begin
                  inc[S_OBJ]    = (c == CH_LBRACE);
                  inc[S_ARR]    = (c == CH_LBRACK);
                  inc[S_STRUCT] = 1'b1;
                  opener        = 1'b1;
                  structural    = 1'b1;
                  depth_in      = depth_up;
               end
               CH_RBRACE, CH_RBRACK: begin
                  inc[S_STRUCT] = 1'b1;
                  structural    = 1'b1;
                  depth_in      = (depth_ff != 32'd0) ? depth_ff - 32'd1 : depth_ff;
               end
               CH_COLON, CH_COMMA: begin
                  inc[S_COLON]  = (c == CH_COLON);
                  inc[S_COMMA]  = (c == CH_COMMA);
                  inc[S_STRUCT] = 1'b1;
                  structural    = 1'b1;
               end
               CH_LOW_T: begin
                  lit_kind_in = LIT_TRUE;
                  lit_pos_in  = 3'd1;
               end
               CH_LOW_F: begin
                  lit_kind_in = LIT_FALSE;
                  lit_pos_in  = 3'd1;
               end
               CH_LOW_N: begin
                  lit_kind_in = LIT_NULL;
                  lit_pos_in  = 3'd1;
               end
               default: begin
                  if ((c == CH_MINUS) || ((c >= CH_ZERO) && (c <= CH_NINE))) begin
                     inc[S_NUM]  = 1'b1;
                     num_open_in = 1'b1;
                  end
               end
            endcase
         end
      end

      prev_mask_in = m;
      byte_pos_in  = (byte_pos_ff == 32'hFFFF_FFFF) ? byte_pos_ff : byte_pos_ff + 32'd1;
   end

   // Saturating counter updates; the maximum depth slot follows the depth.
   always_comb begin
      for (int i = 0; i < NUM_SUM; i++) begin
         cnt_next[i] = (inc[i] && (cnt_ff[i] != {COUNT_WIDTH{1'b1}})) ?
                       cnt_ff[i] + COUNT_WIDTH'(1) : cnt_ff[i];
      end
      maxd_next = cnt_ff[S_MAXD];
      if (opener && (CMP_W'(depth_up) > CMP_W'(cnt_ff[S_MAXD]))) begin
         maxd_next = (CMP_W'(depth_up) > CNT_MAX_EXT) ? {COUNT_WIDTH{1'b1}}
                                                      : COUNT_WIDTH'(depth_up);
      end
      cnt_next[S_MAXD] = maxd_next;
      qdelim_next = (qdelim_inc && (qdelim_ff != {COUNT_WIDTH{1'b1}})) ?
                    qdelim_ff + COUNT_WIDTH'(1) : qdelim_ff;
   end

   // Summary snapshot, clamped to the 32-bit record value. When no
   // quote-inclusive literal was seen, the string count falls back to half
   // the number of delimiting quotes.
   always_comb begin
      for (int i = 0; i < NUM_SUM; i++) begin
         snap_in[i] = (CMP_W'(cnt_next[i]) > POS_MAX_EXT) ? 32'hFFFF_FFFF
                                                          : 32'(CMP_W'(cnt_next[i]));
      end
      if (cnt_next[S_STRLIT] == '0) begin
         snap_in[S_STRLIT] = (CMP_W'(qdelim_next >> 1) > POS_MAX_EXT) ? 32'hFFFF_FFFF
                             : 32'(CMP_W'(qdelim_next >> 1));
      end
      for (int i = 0; i < NUM_SUM; i++) begin
         cnt_in[i] = req_bus.last_byte ? '0 : cnt_next[i];
      end
      qdelim_in = req_bus.last_byte ? '0 : qdelim_next;
   end

   assign mask_rec_in = m;
   assign idx_rec_in  = byte_pos_ff;
   assign pend_new    = {{NUM_SUM{req_bus.last_byte}}, emit_idx_ff & structural, emit_mask_ff};

   // The lowest pending kind goes out first; that is the record order.
   always_comb begin
      sel_kind = KIND_MASK;
      for (int i = NUM_KINDS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel_kind = record_kind_type'(i);
         end
      end
      sel_onehot = NUM_KINDS'(1) << sel_kind;
      final_beat = ((pend_ff & ~sel_onehot) == '0);
   end

   always_comb begin
      if (accept) begin
         pend_in = pend_new;
      end else if (drain) begin
         pend_in = pend_ff & ~sel_onehot;
      end else begin
         pend_in = pend_ff;
      end
   end

   // A new byte enters when nothing is pending or the last pending beat
   // leaves in this cycle.
   assign req_bus.ready = (pend_ff == '0) || (rsp_bus.ready && final_beat);

   assign rsp_bus.valid       = (pend_ff != '0);
   assign rsp_bus.record_kind = sel_kind;
   assign rsp_bus.last_of_run = final_beat;

   always_comb begin
      unique case (sel_kind)
         KIND_MASK:  rsp_bus.record_value = {31'd0, mask_rec_ff};
         KIND_INDEX: rsp_bus.record_value = idx_rec_ff;
         default: begin
            if (sel_kind >= KIND_SUMMARY) begin
               rsp_bus.record_value = snap_ff[4'(sel_kind - KIND_SUMMARY)];
            end else begin
               rsp_bus.record_value = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_incl_ff <= 1'b0;
         emit_idx_ff   <= 1'b0;
         emit_mask_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_QUOTE_INCLUSIVE: quote_incl_ff <= csr_wdata;
            CSR_EMIT_INDEXES:    emit_idx_ff   <= csr_wdata;
            CSR_EMIT_MASK:       emit_mask_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         str_open_ff  <= 1'b0;
         odd_esc_ff   <= 1'b0;
         prev_mask_ff <= 1'b0;
         num_open_ff  <= 1'b0;
         lit_kind_ff  <= LIT_NONE;
         lit_pos_ff   <= '0;
         byte_pos_ff  <= '0;
         depth_ff     <= '0;
         qdelim_ff    <= '0;
         pend_ff      <= '0;
         for (int i = 0; i < NUM_SUM; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         pend_ff <= pend_in;
         if (accept) begin
            qdelim_ff <= qdelim_in;
            for (int i = 0; i < NUM_SUM; i++) begin
               cnt_ff[i] <= cnt_in[i];
            end
            if (req_bus.last_byte) begin
               // End of document: start the next one from a clean state.
               str_open_ff  <= 1'b0;
               odd_esc_ff   <= 1'b0;
               prev_mask_ff <= 1'b0;
               num_open_ff  <= 1'b0;
               lit_kind_ff  <= LIT_NONE;
               lit_pos_ff   <= '0;
               byte_pos_ff  <= '0;
               depth_ff     <= '0;
            end else begin
               str_open_ff  <= str_open_in;
               odd_esc_ff   <= odd_esc_in;
               prev_mask_ff <= prev_mask_in;
               num_open_ff  <= num_open_in;
               lit_kind_ff  <= lit_kind_in;
               lit_pos_ff   <= lit_pos_in;
               byte_pos_ff  <= byte_pos_in;
               depth_ff     <= depth_in;
            end
         end
      end
   end

   // Result payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         mask_rec_ff <= mask_rec_in;
         idx_rec_ff  <= idx_rec_in;
         for (int i = 0; i < NUM_SUM; i++) begin
            snap_ff[i] <= snap_in[i];
         end
      end
   end

endmodule

### bench/tb_top.sv
module tb_top;
   import jss_pkg::*;

   localparam int COUNT_WIDTH = 32;
   localparam longint unsigned COUNT_LIMIT = (64'd1 << COUNT_WIDTH) - 64'd1;
   localparam logic [31:0] POSITION_LIMIT = 32'hFFFF_FFFF;
   // Cycles to let pass once nothing is expected any more. A byte that causes no
   // record is finished in the cycle it is accepted, so this is generous.
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_BYTES = 10;
   localparam int REPORT_LIMIT = 10;

   // One input beat waiting to be sent, and one record the scanner should return.
   typedef struct {
      logic [7:0] data;
      logic       last;
   } doc_beat_type;

   typedef struct {
      record_kind_type kind;
      logic [31:0]     value;
      logic            last;
   } scan_record_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   csr_index_type csr_index;
   logic csr_wdata;

   jss_req_if req_bus ();
   jss_rsp_if rsp_bus ();

   json_structural_scanner #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Bytes waiting for the driver, and the records the scanner still owes us.
   doc_beat_type    pending_bytes[$];
   scan_record_type expected_records[$];
   logic [7:0]      doc_text[$];

   int  error_count = 0;
   int  bytes_sent = 0;
   int  records_checked = 0;
   int  documents_sent = 0;
   int  send_gap = 0;
   int  recv_stall = 0;
   bit  idling_on = 1'b1;

   // Our own copy of the configuration registers, at their reset values.
   bit cfg_quote_incl = 1'b0;
   bit cfg_emit_index = 1'b0;
   bit cfg_emit_mask = 1'b1;

   // Document state of the scanner as we expect it to be.
   bit               str_open = 1'b0;
   bit               escape_odd = 1'b0;
   bit               prev_mask = 1'b0;
   bit               in_number = 1'b0;
   lit_kind_type     lit_kind = LIT_NONE;
   lit_pos_type      lit_pos = '0;
   logic [31:0]      position = '0;
   logic [31:0]      depth = '0;
   longint unsigned  tally[NUM_SUM];
   longint unsigned  quote_pairs = 0;
   string            literal_text[4] = '{"", "true", "false", "null"};

   initial begin
      foreach (tally[i]) tally[i] = 0;
   end

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%s", msg);
   endfunction

   function automatic void bump(input int slot);
      if (tally[slot] < COUNT_LIMIT) tally[slot]++;
   endfunction

   function automatic void push_record(input record_kind_type kind,
                                       input logic [31:0] value);
      scan_record_type rec;
      rec.kind = kind;
      rec.value = value;
      rec.last = 1'b0;
      expected_records.insert(expected_records.size(), rec);
   endfunction

   // Works out the records that one accepted byte causes and updates the
   // document state, exactly as the scanner is meant to.
   function automatic void predict_byte(input logic [7:0] c, input logic last);
      bit              m;
      bit              escaped;
      bit              handled;
      bit              structural;
      int              lit_len;
      int              first_new;
      longint unsigned v;

      first_new = expected_records.size();
      handled = 1'b0;
      structural = 1'b0;

      // String mask. A backslash flips the escape parity; a quote that is not
      // escaped opens or closes a string.
      if (c == CH_BSLASH) begin
         m = str_open;
         escape_odd = !escape_odd;
      end else if (c == CH_QUOTE) begin
         escaped = escape_odd;
         escape_odd = 1'b0;
         if (cfg_quote_incl) m = 1'b1;
         else m = escaped ? str_open : 1'b0;
         if (!escaped) str_open = !str_open;
      end else begin
         escape_odd = 1'b0;
         m = str_open;
      end
      bump(S_BYTES);

      // A literal under way either takes this byte or is dropped, and then the
      // byte is looked at again as if nothing had been going on.
      if (lit_kind != LIT_NONE) begin
         lit_len = literal_text[lit_kind].len();
         if (!m && int'(lit_pos) < lit_len && c == literal_text[lit_kind][lit_pos]) begin
            handled = 1'b1;
            if (int'(lit_pos) + 1 >= lit_len) begin
               bump(S_TRUE + int'(lit_kind) - 1);
               lit_kind = LIT_NONE;
               lit_pos = '0;
            end else begin
               lit_pos = lit_pos + 1'b1;
            end
         end else begin
            lit_kind = LIT_NONE;
            lit_pos = '0;
         end
      end

      if (!handled && in_number) begin
         if (!m && ((c >= "0" && c <= "9") || c == "-" || c == "+" || c == "." ||
                    c == "e" || c == "E")) begin
            handled = 1'b1;
         end else begin
            in_number = 1'b0;
         end
      end

      if (!handled) begin
         if (m) begin
            if (c == CH_QUOTE) begin
               if (!prev_mask) bump(S_STRLIT);
            end else begin
               bump(S_STRCHR);
            end
         end else if (c == CH_QUOTE) begin
            if (quote_pairs < COUNT_LIMIT) quote_pairs++;
         end else if (c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB) begin
            // Whitespace outside strings carries no meaning.
         end else if (c == CH_LBRACE || c == CH_LBRACK) begin
            bump(c == CH_LBRACE ? S_OBJ : S_ARR);
            bump(S_STRUCT);
            if (depth < POSITION_LIMIT) depth++;
            if (depth > tally[S_MAXD]) tally[S_MAXD] = depth;
            structural = 1'b1;
         end else if (c == CH_RBRACE || c == CH_RBRACK) begin
            bump(S_STRUCT);
            if (depth > 0) depth--;
            structural = 1'b1;
         end else if (c == CH_COLON || c == CH_COMMA) begin
            bump(c == CH_COLON ? S_COLON : S_COMMA);
            bump(S_STRUCT);
            structural = 1'b1;
         end else if (c == CH_LOW_T || c == CH_LOW_F || c == CH_LOW_N) begin
            lit_kind = (c == CH_LOW_T) ? LIT_TRUE : (c == CH_LOW_F) ? LIT_FALSE : LIT_NULL;
            lit_pos = 3'd1;
         end else if (c == CH_MINUS || (c >= CH_ZERO && c <= CH_NINE)) begin
            bump(S_NUM);
            in_number = 1'b1;
         end
      end

      if (cfg_emit_mask) push_record(KIND_MASK, {31'd0, m});
      if (structural && cfg_emit_index) push_record(KIND_INDEX, position);
      prev_mask = m;
      if (position < POSITION_LIMIT) position++;

      // The last byte of a document dumps the summary counters and starts over.
      if (last) begin
         for (int i = 0; i < NUM_SUM; i++) begin
            v = tally[i];
            if (i == S_STRLIT && v == 0) v = quote_pairs / 2;
            if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
            push_record(record_kind_type'(KIND_SUMMARY + i), v[31:0]);
            tally[i] = 0;
         end
         str_open = 1'b0;
         escape_odd = 1'b0;
         prev_mask = 1'b0;
         in_number = 1'b0;
         lit_kind = LIT_NONE;
         lit_pos = '0;
         position = '0;
         depth = '0;
         quote_pairs = 0;
      end

      if (expected_records.size() > first_new)
         expected_records[expected_records.size() - 1].last = 1'b1;
   endfunction

   // Driver: presents the head of the byte queue, holds it until it is taken,
   // and predicts the records for every beat at the edge where it is accepted.
   // Gaps come in random bursts while idling is on.
   always @(posedge clock) begin : req_driver
      logic took;
      took = req_bus.valid && req_bus.ready;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.data_byte <= 8'h00;
         req_bus.last_byte <= 1'b0;
      end else begin
         if (took) begin
            predict_byte(req_bus.data_byte, req_bus.last_byte);
            void'(pending_bytes.pop_front());
            bytes_sent++;
         end
         if (!req_bus.valid || took) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_bytes.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 15);
               req_bus.valid <= 1'b0;
            end else begin
               req_bus.valid <= 1'b1;
               req_bus.data_byte <= pending_bytes[0].data;
               req_bus.last_byte <= pending_bytes[0].last;
            end
         end
      end
   end

   // Monitor: every accepted result beat is checked against the oldest
   // expected record. Ready drops in random stall bursts while idling is on.
   always @(posedge clock) begin : rsp_monitor
      scan_record_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            records_checked++;
            if (expected_records.size() == 0) begin
               flag_error($sformatf("unexpected result: kind %0d value %0d last %0d",
                                    rsp_bus.record_kind, rsp_bus.record_value,
                                    rsp_bus.last_of_run));
            end else begin
               want = expected_records.pop_front();
               if (rsp_bus.record_kind !== want.kind || rsp_bus.record_value !== want.value ||
                   rsp_bus.last_of_run !== want.last) begin
                  flag_error($sformatf({"mismatch on result %0d: expected kind %0d value %0d ",
                                        "last %0d, got kind %0d value %0d last %0d"},
                                       records_checked, want.kind, want.value, want.last,
                                       rsp_bus.record_kind, rsp_bus.record_value,
                                       rsp_bus.last_of_run));
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_bus.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            recv_stall = $urandom_range(0, 15);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic void queue_byte(input logic [7:0] c, input logic last);
      doc_beat_type beat;
      beat.data = c;
      beat.last = last;
      pending_bytes.insert(pending_bytes.size(), beat);
   endfunction

   function automatic void queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0);
   endfunction

   function automatic void add_char(input logic [7:0] c);
      doc_text.insert(doc_text.size(), c);
   endfunction

   function automatic void add_space();
      int pick;
      pick = $urandom_range(0, 15);
      case (pick)
         0: add_char(CH_SPACE);
         1: add_char(CH_LF);
         2: add_char(CH_CR);
         3: add_char(CH_TAB);
         default: ;
      endcase
   endfunction

   // A string with plain letters, escapes, backslash runs of either parity and
   // arbitrary bytes. An odd run right before the closing quote leaves the
   // string open, which is exactly the kind of damage worth throwing at it.
   function automatic void gen_string();
      int count;
      int pick;
      add_char(CH_QUOTE);
      count = $urandom_range(0, 5);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            add_char(8'($urandom_range(int'("a"), int'("z"))));
         end else if (pick < 75) begin
            add_char(CH_BSLASH);
            case ($urandom_range(0, 2))
               0: add_char(CH_QUOTE);
               1: add_char(CH_BSLASH);
               default: add_char("n");
            endcase
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 3)) add_char(CH_BSLASH);
         end else if (pick < 95) begin
            add_char(8'($urandom_range(128, 255)));
         end else begin
            add_char(8'($urandom_range(0, 255)));
         end
      end
      add_char(CH_QUOTE);
   endfunction

   // One JSON value, mostly well formed, sometimes with a cut literal or noise.
   function automatic void gen_value(input int level);
      int pick;
      int count;
      int kind;
      int cut;
      pick = $urandom_range(0, 99);
      if (pick < 20 && level < 3) begin
         add_char(CH_LBRACE);
         count = $urandom_range(0, 3);
         for (int i = 0; i < count; i++) begin
            if (i > 0) add_char(CH_COMMA);
            add_space();
            gen_string();
            add_space();
            add_char(CH_COLON);
            add_space();
            gen_value(level + 1);
         end
         add_space();
         add_char(CH_RBRACE);
      end else if (pick < 38 && level < 3) begin
         add_char(CH_LBRACK);
         count = $urandom_range(0, 4);
         for (int i = 0; i < count; i++) begin
            if (i > 0) add_char(CH_COMMA);
            add_space();
            gen_value(level + 1);
         end
         add_char(CH_RBRACK);
      end else if (pick < 58) begin
         gen_string();
      end else if (pick < 74) begin
         if ($urandom_range(0, 2) == 0) add_char(CH_MINUS);
         repeat ($urandom_range(1, 3)) add_char(8'($urandom_range(int'("0"), int'("9"))));
         if ($urandom_range(0, 2) == 0) begin
            add_char(CH_DOT);
            repeat ($urandom_range(1, 2)) add_char(8'($urandom_range(int'("0"), int'("9"))));
         end
         if ($urandom_range(0, 3) == 0) begin
            add_char($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
            if ($urandom_range(0, 1)) add_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            add_char(8'($urandom_range(int'("0"), int'("9"))));
         end
      end else if (pick < 86) begin
         kind = $urandom_range(1, 3);
         for (int i = 0; i < literal_text[kind].len(); i++) add_char(literal_text[kind][i]);
      end else if (pick < 94) begin
         // A literal that breaks off; whatever follows gets a second look.
         kind = $urandom_range(1, 3);
         cut = $urandom_range(1, literal_text[kind].len() - 1);
         for (int i = 0; i < cut; i++) add_char(literal_text[kind][i]);
         if ($urandom_range(0, 1)) add_char(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 3)) add_char(8'($urandom_range(0, 255)));
      end
   endfunction

   // Builds one document and queues it, the final byte flagged as last.
   function automatic int queue_document();
      doc_text.delete();
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(3, 10)) add_char(8'($urandom_range(0, 255)));
      end else begin
         // Now and then a stray closer up front meets the depth at zero, where it must hold.
         if ($urandom_range(0, 11) == 0) add_char($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACK);
         add_space();
         gen_value(0);
         add_space();
      end
      foreach (doc_text[i]) queue_byte(doc_text[i], i == doc_text.size() - 1);
      documents_sent++;
      return doc_text.size();
   endfunction

   // Register writes happen only with the scanner idle, so our copy of the
   // configuration can change at the same edge.
   task automatic write_register(input csr_index_type index, input logic value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_QUOTE_INCLUSIVE: cfg_quote_incl = value;
         CSR_EMIT_INDEXES:    cfg_emit_index = value;
         CSR_EMIT_MASK:       cfg_emit_mask = value;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // The sender holds back here until every byte is gone and every expected
   // record has come back, then lets the scanner settle.
   task automatic wait_until_drained();
      while (pending_bytes.size() != 0 || req_bus.valid || expected_records.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register settings of the random phases: quote-inclusive mask, index
   // records, mask records. The last phase runs without any idling.
   bit phase_quote[5] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
   bit phase_index[5] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
   bit phase_mask[5]  = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

   initial begin : stimulus
      int phase_bytes;
      csr_we <= 1'b0;
      csr_index <= CSR_QUOTE_INCLUSIVE;
      csr_wdata <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed document, first half under the reset configuration: a closer
      // at depth zero, a backslash outside any string, a string holding 0xFF
      // and an escaped quote, then an open array and a number with exponent.
      @(negedge clock);
      queue_text("]\\{\"k");
      queue_byte(8'hFF, 1'b0);
      queue_text("\\\"\":[-1e");
      wait_until_drained();

      // Second half after switching to quote-inclusive masking and index
      // records mid-document: a literal broken by a comma, an empty string,
      // a complete null, a zero byte and a literal cut off by the document end.
      write_register(CSR_QUOTE_INCLUSIVE, 1'b1);
      write_register(CSR_EMIT_INDEXES, 1'b1);
      @(negedge clock);
      queue_text("tr,\"\"null}");
      queue_byte(8'h00, 1'b0);
      queue_byte(CH_LOW_F, 1'b1);
      documents_sent++;
      wait_until_drained();

      // Random documents, one register setting per phase.
      for (int p = 0; p < 5; p++) begin
         write_register(CSR_QUOTE_INCLUSIVE, phase_quote[p]);
         write_register(CSR_EMIT_INDEXES, phase_index[p]);
         write_register(CSR_EMIT_MASK, phase_mask[p]);
         @(negedge clock);
         if (p == 4) idling_on = 1'b0;
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) phase_bytes += queue_document();
         wait_until_drained();
      end

      $display("Sent %0d bytes in %0d documents over 6 register settings,", bytes_sent,
               documents_sent);
      $display("and checked %0d result beats against the predicted records.", records_checked);
      if (error_count == 0) begin
         $display("json_structural_scanner test passed");
      end else begin
         $display("json_structural_scanner test failed");
      end
      $finish;
   end

   // Far beyond the slowest correct run: every byte waiting out the longest
   // stalls on both sides, plus the summaries at each document end.
   initial begin : watchdog
      #(20 * 400000);
      $display("json_structural_scanner test failed");
      $finish;
   end

endmodule
